### hw/rtl/blp_pkg.sv
// Shared types and constants of the beeper level packetizer.
package blp_pkg;

  localparam int unsigned AddrW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 11;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] MaxPacket  = CountW'(1024);
  localparam logic [CountW-1:0] MinPacket  = CountW'(2);
  localparam logic [CountW-1:0] CountSat   = {CountW{1'b1}};

  localparam logic [ByteW-1:0]  PortLowRst  = 8'hFE;
  localparam logic [ByteW-1:0]  HighCodeRst = 8'd127;
  localparam logic [CountW-1:0] PktLenRst   = CountW'(700);
  localparam logic [CountW-1:0] TimeoutRst  = CountW'(700);

  typedef enum logic [CfgIdxW-1:0] {
    CfgPortLow  = 2'd0,
    CfgHighCode = 2'd1,
    CfgPktLen   = 2'd2,
    CfgTimeout  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FuncPortWrite = 1'b0,
    FuncTick      = 1'b1
  } func_e;

  typedef struct packed {
    logic [ByteW-1:0]  sample_code;
    logic [CountW-1:0] repeat_count;
    logic              packet_end;
    logic              last_of_item;
  } result_t;

endpackage

### hw/rtl/beeper_level_packetizer.sv
// Top level of the beeper level packetizer: input stage, packet logic, result queue.
//
//  Channel   Dir  tdata (low bit up)                    tuser            tlast
//  s_axis    in   port_address[15:0], write_value[7:0]  func             -
//  m_axis    out  sample_code[7:0], repeat_count[10:0], last_of_item     packet_end
//                 zero pad to 24 bits
//  cfg       in   cfg_we_i / cfg_idx_i / cfg_wdata_i, one write per cycle, no read-back
//
// Each input transfer is held in the input register, then the packet logic turns it into
// zero, one or two results combinationally; a new input is taken every cycle while the
// result queue has room. Results pass the input register and the result queue to m_axis.
// The result queue holds four entries; the input stage advances only while the queue has
// room for two results, so a stalled output side backs up to s_axis_tready after that.
// Reset (rst_ni low, asynchronous) empties both stages and resets configuration and packet state.
module beeper_level_packetizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] port_address, [23:16] write_value
  input  logic        s_axis_tuser,   // [0] func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] sample_code, [18:8] repeat_count, rest zero
  output logic        m_axis_tuser,   // [0] last_of_item
  output logic        m_axis_tlast    // packet_end
);

  localparam int unsigned CW = blp_pkg::CountW;

  // configuration registers
  logic [7:0]    port_low_q, high_code_q;
  logic [CW-1:0] pkt_len_q, timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_low_q  <= blp_pkg::PortLowRst;
      high_code_q <= blp_pkg::HighCodeRst;
      pkt_len_q   <= blp_pkg::PktLenRst;
      timeout_q   <= blp_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      case (blp_pkg::cfg_idx_e'(cfg_idx_i))
        blp_pkg::CfgPortLow:  port_low_q  <= cfg_wdata_i[7:0];
        blp_pkg::CfgHighCode: high_code_q <= cfg_wdata_i[7:0];
        blp_pkg::CfgPktLen:   pkt_len_q   <= cfg_wdata_i;
        blp_pkg::CfgTimeout:  timeout_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic        in_vld_q;
  logic        in_func_q;
  logic [15:0] in_addr_q;
  logic [7:0]  in_val_q;
  logic        proc_go;
  logic        s_fire;

  // result queue
  blp_pkg::result_t q_mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       pop;

  // Process the held item only while two queue slots are free.
  assign proc_go       = in_vld_q && (cnt_q <= 3'd2);
  assign s_axis_tready = !in_vld_q || proc_go;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_func_q <= s_axis_tuser;
      in_addr_q <= s_axis_tdata[15:0];
      in_val_q  <= s_axis_tdata[23:16];
    end
  end

  // packet state
  logic          level_q, level_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          prev_lvl_q, prev_lvl_d;
  logic          recent_q, recent_d;
  logic [CW-1:0] ticks_q, ticks_d;

  logic [CW-1:0] len_eff;
  logic [CW-1:0] ticks_inc, gap, gap_cap, fill_inc;
  logic          recent_tmp;
  blp_pkg::result_t res_a, res_b;
  logic [1:0]    n_push;

  function automatic logic [7:0] code_of(input logic lvl, input logic [7:0] hi);
    return lvl ? hi : 8'd0;
  endfunction

  // Clamp the packet length to its legal range.
  always_comb begin
    if (pkt_len_q < blp_pkg::MinPacket) begin
      len_eff = blp_pkg::MinPacket;
    end else if (pkt_len_q > blp_pkg::MaxPacket) begin
      len_eff = blp_pkg::MaxPacket;
    end else begin
      len_eff = pkt_len_q;
    end
  end

  always_comb begin
    level_d    = level_q;
    fill_d     = fill_q;
    prev_lvl_d = prev_lvl_q;
    recent_d   = recent_q;
    ticks_d    = ticks_q;
    res_a      = '0;
    res_b      = '0;
    n_push     = 2'd0;
    recent_tmp = recent_q;
    ticks_inc  = ticks_q;
    gap        = '0;
    gap_cap    = len_eff - CW'(2);
    fill_inc   = fill_q + CW'(1);

    if (in_func_q == blp_pkg::FuncPortWrite) begin
      if (in_addr_q[7:0] == port_low_q) begin
        level_d = in_val_q[4] ^ in_val_q[3];
      end
    end else if (fill_q == '0) begin
      // Age the previous packet; forget it once the timeout is reached.
      if (recent_q) begin
        if (ticks_q != blp_pkg::CountSat) begin
          ticks_inc = ticks_q + CW'(1);
        end
        if (ticks_inc >= timeout_q) begin
          recent_tmp = 1'b0;
        end
      end
      ticks_d  = ticks_inc;
      recent_d = recent_tmp;
      if (level_q != prev_lvl_q) begin
        res_a.sample_code  = code_of(level_q, high_code_q);
        res_a.repeat_count = CW'(1);
        res_a.last_of_item = 1'b1;
        n_push             = 2'd1;
        fill_d             = CW'(1);
        if (recent_tmp) begin
          // Fill the gap since the previous packet with one run of its level.
          gap = ticks_inc - CW'(1);
          if (gap > gap_cap) begin
            gap = gap_cap;
          end
          fill_d   = gap + CW'(1);
          recent_d = 1'b0;
          if (gap != '0) begin
            res_b  = res_a;
            res_a  = '0;
            res_a.sample_code  = code_of(prev_lvl_q, high_code_q);
            res_a.repeat_count = gap;
            n_push = 2'd2;
          end
        end
      end
    end else begin
      res_a.sample_code  = code_of(level_q, high_code_q);
      res_a.repeat_count = CW'(1);
      res_a.last_of_item = 1'b1;
      n_push             = 2'd1;
      fill_d             = fill_inc;
      if (fill_inc >= len_eff) begin
        res_a.packet_end = 1'b1;
        prev_lvl_d       = level_q;
        recent_d         = 1'b1;
        ticks_d          = '0;
        fill_d           = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= 1'b0;
      fill_q     <= '0;
      prev_lvl_q <= 1'b0;
      recent_q   <= 1'b0;
      ticks_q    <= '0;
    end else if (proc_go) begin
      level_q    <= level_d;
      fill_q     <= fill_d;
      prev_lvl_q <= prev_lvl_d;
      recent_q   <= recent_d;
      ticks_q    <= ticks_d;
    end
  end

  // Queue write: up to two entries per cycle, in result order.
  logic [1:0] push_n;
  assign push_n = proc_go ? n_push : 2'd0;
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem_q[wr_ptr_q] <= res_a;
    end
    if (push_n == 2'd2) begin
      q_mem_q[wr_ptr_q + 2'd1] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_q + {1'b0, push_n} - {2'b0, pop};
    end
  end

  blp_pkg::result_t head;
  assign head          = q_mem_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tdata  = {5'd0, head.repeat_count, head.sample_code};
  assign m_axis_tuser  = head.last_of_item;
  assign m_axis_tlast  = head.packet_end;

endmodule

### hw/rtl/blp_checker.sv
// Port checker for the beeper level packetizer, bound to the top level.
module blp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a run always covers at least one sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:8] != 11'd0)
    else $error("zero repeat count");

  // packet end falls on a single sample that closes its item
  a_end_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser && m_axis_tdata[18:8] == 11'd1)
    else $error("bad packet end transfer");

  // a gap run is always followed by the sample that starts the packet
  a_gap_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid)
    else $error("gap run without following sample");

endmodule

bind beeper_level_packetizer blp_checker u_blp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### dv/beeper_level_packetizer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the beeper level packetizer with a predictor and in-order result check.
module beeper_level_packetizer_tb;
  import blp_pkg::*;

  localparam int unsigned ResetCycles     = 9;
  localparam int unsigned SettleCycles    = 8;      // input register plus packet stage, with margin
  localparam int unsigned LongHold        = 60;     // receiver stall that backs up into s_axis
  localparam int unsigned CycleLimit      = 400000;
  localparam int unsigned PhaseCount      = 11;
  localparam int unsigned PhaseItems      = 20;
  localparam int unsigned LongPacketLen   = 100;
  localparam int unsigned LongPacketTicks = 110;

  // One bus operation as offered on s_axis.
  typedef struct packed {
    func_e             func;
    logic [AddrW-1:0]  port_address;
    logic [ByteW-1:0]  write_value;
  } bus_op_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [10:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [15:0] port_address, [23:16] write_value
  logic        s_axis_tuser  = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] sample_code, [18:8] repeat_count, rest zero
  logic        m_axis_tuser;         // [0] last_of_item
  logic        m_axis_tlast;         // packet_end

  // Register copies and packet state of the predictor.
  logic [ByteW-1:0]  port_low_q  = PortLowRst;
  logic [ByteW-1:0]  high_code_q = HighCodeRst;
  logic [CountW-1:0] pkt_len_q   = PktLenRst;
  logic [CountW-1:0] timeout_q   = TimeoutRst;
  logic              level_q       = 1'b0;
  logic              prev_level_q  = 1'b0;
  logic              prev_recent_q = 1'b0;
  int unsigned       fill_q        = 0;
  int unsigned       gap_ticks_q   = 0;

  bus_op_t     op_queue[$];      // operations waiting for the driver
  result_t     due_samples[$];   // predicted results, oldest first
  bus_op_t     cur_op        = '0;
  bit          offer_live    = 1'b0;
  bit          steady        = 1'b0; // suppress idling on both sides for the phase
  int unsigned tx_gap        = 0;
  int unsigned rx_gap        = 0;
  int unsigned results_seen  = 0;
  int unsigned failures      = 0;
  int unsigned cycle_count   = 0;

  beeper_level_packetizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------------

  function automatic logic [ByteW-1:0] level_code(logic lvl);
    return lvl ? high_code_q : '0;
  endfunction

  function automatic void queue_sample(logic [ByteW-1:0] code, int unsigned count, logic pend,
                                       logic last);
    result_t r;
    r.sample_code  = code;
    r.repeat_count = CountW'(count);
    r.packet_end   = pend;
    r.last_of_item = last;
    due_samples.push_back(r);
  endfunction

  // Advance the packet state by one accepted operation and queue the samples it produces.
  function automatic void predict_samples(bus_op_t op);
    int unsigned len;
    int unsigned gap;
    len = pkt_len_q;
    if (len < MinPacket) len = MinPacket;
    if (len > MaxPacket) len = MaxPacket;

    if (op.func == FuncPortWrite) begin
      // Only the low address byte selects the port; level is bit 4 xor bit 3.
      if (op.port_address[7:0] == port_low_q) begin
        level_q = op.write_value[4] ^ op.write_value[3];
      end
    end else if (fill_q == 0) begin
      // Idle between packets: age the previous packet, forget it on timeout.
      if (prev_recent_q) begin
        if (gap_ticks_q < CountSat) gap_ticks_q++;
        if (gap_ticks_q >= timeout_q) prev_recent_q = 1'b0;
      end
      if (level_q != prev_level_q) begin
        if (prev_recent_q) begin
          // Fill the silence since the last packet with one run of the old level, clipped so
          // the new packet still fits.
          gap = gap_ticks_q - 1;
          if (gap > len - 2) gap = len - 2;
          if (gap > 0) queue_sample(level_code(prev_level_q), gap, 1'b0, 1'b0);
          fill_q        = gap + 1;
          prev_recent_q = 1'b0;
        end else begin
          fill_q = 1;
        end
        queue_sample(level_code(level_q), 1, 1'b0, 1'b1);
      end
    end else begin
      fill_q++;
      if (fill_q >= len) begin
        queue_sample(level_code(level_q), 1, 1'b1, 1'b1);
        prev_level_q  = level_q;
        prev_recent_q = 1'b1;
        gap_ticks_q   = 0;
        fill_q        = 0;
      end else begin
        queue_sample(level_code(level_q), 1, 1'b0, 1'b1);
      end
    end
  endfunction

  function automatic int unsigned draw_idle();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Input side: drive on the falling edge, note the transfer on the rising edge
  // ---------------------------------------------------------------------------------------------

  always @(negedge clk_i) begin : stim_drive
    if (rst_ni && !offer_live) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (op_queue.size() != 0) begin
        cur_op     = op_queue.pop_front();
        offer_live = 1'b1;
      end
    end
    // Hold the offer until it transfers; scramble the bus while nothing is offered.
    s_axis_tvalid <= offer_live;
    s_axis_tdata  <= offer_live ? {cur_op.write_value, cur_op.port_address} : 24'($urandom);
    s_axis_tuser  <= offer_live ? cur_op.func : 1'($urandom);
  end

  always @(posedge clk_i) begin : stim_accept
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_samples(cur_op);
      offer_live = 1'b0;
      tx_gap     = draw_idle();
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Output side: ready on the falling edge, check every result transfer on the rising edge
  // ---------------------------------------------------------------------------------------------

  always @(negedge clk_i) begin : result_ready
    if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_samples.size() == 0) begin
        $error("result with nothing due: tdata %h, tlast %b, tuser %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        failures++;
      end else begin
        want = due_samples.pop_front();
        check_field("sample_code", want.sample_code, m_axis_tdata[7:0]);
        check_field("repeat_count", want.repeat_count, m_axis_tdata[18:8]);
        check_field("packet_end", want.packet_end, m_axis_tlast);
        check_field("last_of_item", want.last_of_item, m_axis_tuser);
      end
      results_seen++;
      // Now and then stall for a long stretch so the result queue fills and s_axis backs up.
      rx_gap = (results_seen % 150 == 75) ? LongHold : draw_idle();
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------------------------

  task automatic queue_write(logic [AddrW-1:0] addr, logic [ByteW-1:0] val);
    bus_op_t op;
    op.func         = FuncPortWrite;
    op.port_address = addr;
    op.write_value  = val;
    op_queue.push_back(op);
  endtask

  task automatic queue_ticks(int unsigned n);
    bus_op_t op;
    repeat (n) begin
      // Address and data are don't-care on a tick; keep them random.
      op.func         = FuncTick;
      op.port_address = AddrW'($urandom);
      op.write_value  = ByteW'($urandom);
      op_queue.push_back(op);
    end
  endtask

  // Wait until every queued operation has transferred and every result has arrived, then let
  // operations without a result clear the pipeline.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (op_queue.size() != 0 || offer_live || due_samples.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write all four registers back to back; the block is idle here.
  task automatic load_config(logic [ByteW-1:0] port_low, logic [ByteW-1:0] high_code,
                             logic [CountW-1:0] pkt_len, logic [CountW-1:0] timeout);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgPortLow;
    cfg_wdata_i <= {3'b000, port_low};
    port_low_q  = port_low;
    @(negedge clk_i);
    cfg_idx_i   <= CfgHighCode;
    cfg_wdata_i <= {3'b000, high_code};
    high_code_q = high_code;
    @(negedge clk_i);
    cfg_idx_i   <= CfgPktLen;
    cfg_wdata_i <= pkt_len;
    pkt_len_q   = pkt_len;
    @(negedge clk_i);
    cfg_idx_i   <= CfgTimeout;
    cfg_wdata_i <= timeout;
    timeout_q   = timeout;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed traffic: a write to the selected port followed by a run of ticks, with
  // bare tick runs, writes to random addresses and back-to-back writes mixed in.
  task automatic fill_random(int unsigned target);
    int unsigned counted;
    int unsigned pick;
    int unsigned n;
    logic [AddrW-1:0] addr;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        n = $urandom_range(1, 10);
        queue_write({ByteW'($urandom), port_low_q}, ByteW'($urandom));
        queue_ticks(n);
        counted += n + 1;
      end else if (pick < 75) begin
        n = $urandom_range(1, 6);
        queue_ticks(n);
        counted += n;
      end else if (pick < 90) begin
        addr = AddrW'($urandom);
        queue_write(addr, ByteW'($urandom));
        if (addr[7:0] == port_low_q) counted++;
      end else begin
        queue_write({ByteW'($urandom), port_low_q}, ByteW'($urandom));
        queue_write({ByteW'($urandom), port_low_q}, ByteW'($urandom));
        counted += 2;
      end
    end
  endtask

  initial begin : sequencer
    logic [ByteW-1:0]  port_low;
    logic [ByteW-1:0]  high_code;
    logic [CountW-1:0] pkt_len;
    logic [CountW-1:0] timeout;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: level equal to the last packet gives no result, a foreign port is
    // ignored, then a packet starts and follows the level.
    queue_ticks(1);
    queue_write(16'h00FF, 8'hFF);
    queue_write(16'hFFFE, 8'h08);
    queue_ticks(2);
    queue_write(16'h00FE, 8'h18);
    queue_ticks(1);
    queue_write(16'h12FE, 8'h10);
    queue_ticks(1);
    wait_drained();

    // Lower the length under a packet in progress: it ends on the next sample. Then hold the
    // level past the end so the gap run has to be clipped to length minus two.
    load_config(8'h00, 8'hFF, 11'd3, 11'd40);
    queue_ticks(7);
    queue_write(16'hA500, 8'h00);
    queue_ticks(2);
    wait_drained();

    // Length below range clamps to two; zero timeout forgets a packet on the first tick.
    load_config(8'h00, 8'h00, 11'd0, 11'd0);
    queue_write(16'h5A00, 8'h08);
    queue_ticks(2);
    queue_write(16'h0000, 8'hF0);
    queue_ticks(2);
    wait_drained();

    // Random phases, the first few pinned to register extremes.
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      port_low  = ByteW'($urandom);
      high_code = ByteW'($urandom);
      pkt_len   = CountW'($urandom_range(2, 9));
      timeout   = CountW'($urandom_range(2, 30));
      case (ph)
        0: begin
          high_code = 8'hFF;
          pkt_len   = 11'd2;
          timeout   = 11'd1024;
        end
        1: begin
          port_low = 8'h00;
          pkt_len  = 11'd1;
          timeout  = 11'd1;
        end
        2: begin
          port_low  = 8'hFF;
          high_code = 8'h00;
          timeout   = 11'd0;
        end
        3: begin
          pkt_len = 11'd2047;
          timeout = 11'd2047;
        end
        4: timeout = 11'd2;
        default: ;
      endcase
      steady = (ph % 3 == 2);
      load_config(port_low, high_code, pkt_len, timeout);
      fill_random(PhaseItems);
      wait_drained();
    end

    // One long packet: force a level change, run it to its end, idle a little and go back to
    // the old level so a gap run is emitted.
    steady = 1'b0;
    load_config(ByteW'($urandom), ByteW'($urandom), CountW'(LongPacketLen), 11'd2047);
    queue_write({ByteW'($urandom), port_low_q},
                {3'($urandom), 1'b0, ~prev_level_q, 3'($urandom)});
    queue_ticks(LongPacketTicks);
    queue_write({ByteW'($urandom), port_low_q}, 8'h08);
    queue_write({ByteW'($urandom), port_low_q}, 8'h00);
    queue_write({ByteW'($urandom), port_low_q},
                {3'($urandom), 1'b0, prev_level_q, 3'($urandom)});
    queue_ticks(20);
    wait_drained();

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
